FILE: rtl/mqmb_pkg.sv
// Shared types, request codes and default sizes of the message mailbox.
package mqmb_pkg;

   // Field widths of the request and response words.
   localparam int REQ_W   = 2;
   localparam int ID_W    = 4;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;

   // Largest receive buffer that a receive is granted; a larger request is cut to it.
   localparam int RECV_CAP = 64;

   // Default geometry of the mailbox.
   localparam int QUEUES_DEFAULT    = 8;
   localparam int DEPTH_DEFAULT     = 8;
   localparam int MAX_BYTES_DEFAULT = 64;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_CREATE  = 2'd0,
      REQ_SEND    = 2'd1,
      REQ_RECEIVE = 2'd2,
      REQ_DESTROY = 2'd3
   } req_code_type;

   // Status codes of a response word.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

endpackage

FILE: rtl/mqmb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mqmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/multi_queue_message_mailbox.sv
// Top level of the multi-queue message mailbox.
//
//   Channel   Direction  Handshake            Word
//   req_      in         req_valid/req_stall  type, queue id, data byte, last, max length
//   rsp_      out        rsp_valid/rsp_stall  status, value, byte, byte valid, last
//
// Create, destroy and send are handled as accepted; send bytes stream one per cycle
// while req_stall is low. A receive reads the slot length into ST_LEN, then in ST_STREAM
// reads bytes via the RAM read register into the response register, one per cycle while
// the response is not stalled; input is stalled until its last byte leaves.
// Reset clears the queue table and send state at once; the stores need no clearing.
// A stalled response word stalls all further input.
module multi_queue_message_mailbox #(
   parameter int QUEUES    = mqmb_pkg::QUEUES_DEFAULT,
   parameter int DEPTH     = mqmb_pkg::DEPTH_DEFAULT,
   parameter int MAX_BYTES = mqmb_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mqmb_pkg::REQ_W-1:0]  req_type,
   input  logic [mqmb_pkg::ID_W-1:0]   req_queue_id,
   input  logic [mqmb_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                        req_last_byte,
   input  logic [mqmb_pkg::LEN_W-1:0]  req_max_len,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_status,
   output logic [mqmb_pkg::LEN_W-1:0]  rsp_value,
   output logic [mqmb_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_last
);

   import mqmb_pkg::*;

   localparam int QW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int SW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int LW   = $clog2(MAX_BYTES + 1);
   localparam int CMPW = (LW > LEN_W) ? LW : LEN_W;
   localparam int SAW  = $clog2(QUEUES * DEPTH);
   localparam int MAW  = $clog2(QUEUES * DEPTH * MAX_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_STREAM
   } rx_state_type;

   // Queue table and send state.
   rx_state_type     state_ff, state_in;
   logic             in_use_ff [QUEUES];
   logic             in_use_in [QUEUES];
   logic [SW-1:0]    wslot_ff  [QUEUES];
   logic [SW-1:0]    wslot_in  [QUEUES];
   logic [SW-1:0]    rslot_ff  [QUEUES];
   logic [SW-1:0]    rslot_in  [QUEUES];
   logic [CW-1:0]    count_ff  [QUEUES];
   logic [CW-1:0]    count_in  [QUEUES];
   logic [LW-1:0]    prog_ff, prog_in;
   logic             ovf_ff, ovf_in;
   logic [ID_W-1:0]  sq_ff, sq_in;

   // Receive state.
   logic [QW-1:0]    rq_ff, rq_in;
   logic [SW-1:0]    rs_ff, rs_in;
   logic [LEN_W-1:0] mlen_ff, mlen_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [LW-1:0]    issue_ff, issue_in;
   logic [LW-1:0]    sent_ff, sent_in;
   logic             dv_ff, dv_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_ff, status_in;
   logic [LEN_W-1:0]  value_ff, value_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              bv_ff, bv_in;
   logic              last_ff, last_in;

   // Memory ports.
   logic              sl_we, sl_re;
   logic [SAW-1:0]    sl_waddr, sl_raddr;
   logic [LW-1:0]     sl_wdata, sl_rdata;
   logic              msg_we, msg_re;
   logic [MAW-1:0]    msg_waddr, msg_raddr;
   logic [BYTE_W-1:0] msg_rdata;

   // Helpers.
   logic             accept, pop, out_free, move, issue;
   logic             id_ok, send_ok, free_found;
   logic [QW-1:0]    idq, free_q;
   logic [ID_W-1:0]  sq_cur;
   logic [LW-1:0]    prog_next;
   logic             ovf_next;
   logic [CMPW-1:0]  len_c;

   function automatic logic [SAW-1:0] slot_addr(input logic [QW-1:0] q,
                                                input logic [SW-1:0] s);
      slot_addr = SAW'(int'(q) * DEPTH + int'(s));
   endfunction

   function automatic logic [MAW-1:0] byte_addr(input logic [QW-1:0] q,
                                                input logic [SW-1:0] s,
                                                input logic [LW-1:0] off);
      byte_addr = MAW'((int'(q) * DEPTH + int'(s)) * MAX_BYTES + int'(off));
   endfunction

   // Stores: slot lengths and message bytes.
   mqmb_ram #(.WIDTH(LW), .DEPTH(QUEUES * DEPTH)) u_len_ram (
      .clock (clock),
      .we    (sl_we),
      .waddr (sl_waddr),
      .wdata (sl_wdata),
      .re    (sl_re),
      .raddr (sl_raddr),
      .rdata (sl_rdata)
   );

   mqmb_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUES * DEPTH * MAX_BYTES)) u_msg_ram (
      .clock (clock),
      .we    (msg_we),
      .waddr (msg_waddr),
      .wdata (req_data_byte),
      .re    (msg_re),
      .raddr (msg_raddr),
      .rdata (msg_rdata)
   );

   // Handshake.
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || pop;
   assign id_ok     = int'(req_queue_id) < QUEUES;
   assign idq       = req_queue_id[QW-1:0];

   // Lowest free queue.
   always_comb begin
      free_found = 1'b0;
      free_q     = '0;
      for (int q = QUEUES - 1; q >= 0; q--) begin
         if (!in_use_ff[q]) begin
            free_found = 1'b1;
            free_q     = QW'(q);
         end
      end
   end

   // Send checks for the current byte.
   always_comb begin
      sq_cur  = (prog_ff == '0) ? req_queue_id : sq_ff;
      send_ok = !ovf_ff && (req_queue_id == sq_cur) && id_ok &&
                in_use_ff[idq] && (count_ff[idq] < CW'(DEPTH)) &&
                (prog_ff < LW'(MAX_BYTES));
      prog_next = send_ok ? prog_ff + LW'(1) : prog_ff;
      ovf_next  = ovf_ff || !send_ok;
   end

   // Next-state logic.
   always_comb begin
      state_in     = state_ff;
      in_use_in    = in_use_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      count_in     = count_ff;
      prog_in      = prog_ff;
      ovf_in       = ovf_ff;
      sq_in        = sq_ff;
      rq_in        = rq_ff;
      rs_in        = rs_ff;
      mlen_in      = mlen_ff;
      len_in       = len_ff;
      issue_in     = issue_ff;
      sent_in      = sent_ff;
      dv_in        = dv_ff;
      rsp_valid_in = pop ? 1'b0 : rsp_valid_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      byte_in      = byte_ff;
      bv_in        = bv_ff;
      last_in      = last_ff;
      sl_we        = 1'b0;
      sl_waddr     = slot_addr(idq, wslot_ff[idq]);
      sl_wdata     = prog_next;
      sl_re        = 1'b0;
      sl_raddr     = slot_addr(idq, rslot_ff[idq]);
      msg_we       = 1'b0;
      msg_waddr    = byte_addr(idq, wslot_ff[idq], prog_ff);
      msg_re       = 1'b0;
      msg_raddr    = byte_addr(rq_ff, rs_ff, issue_ff);
      move         = 1'b0;
      issue        = 1'b0;
      len_c        = CMPW'(sl_rdata);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Every accepted word but a plain send byte or a successful receive answers with one word.
               rsp_valid_in = 1'b1;
               status_in    = STATUS_ERROR;
               value_in     = '0;
               byte_in      = '0;
               bv_in        = 1'b0;
               last_in      = 1'b1;
               unique case (req_code_type'(req_type))
                  REQ_CREATE: begin
                     if (free_found) begin
                        in_use_in[free_q] = 1'b1;
                        wslot_in[free_q]  = '0;
                        rslot_in[free_q]  = '0;
                        count_in[free_q]  = '0;
                        if (prog_ff != '0 && sq_ff == ID_W'(free_q)) begin
                           ovf_in = 1'b1;
                        end
                        status_in = STATUS_OK;
                        value_in  = LEN_W'(free_q);
                     end
                  end
                  REQ_SEND: begin
                     sq_in  = sq_cur;
                     msg_we = send_ok;
                     if (req_last_byte) begin
                        if (!ovf_next) begin
                           sl_we = 1'b1;
                           wslot_in[idq] = (wslot_ff[idq] == SW'(DEPTH - 1)) ?
                                           '0 : wslot_ff[idq] + SW'(1);
                           count_in[idq] = count_ff[idq] + CW'(1);
                           status_in     = STATUS_OK;
                        end
                        prog_in = '0;
                        ovf_in  = 1'b0;
                     end else begin
                        prog_in      = prog_next;
                        ovf_in       = ovf_next;
                        rsp_valid_in = pop ? 1'b0 : rsp_valid_ff;
                        status_in    = status_ff;
                        value_in     = value_ff;
                        byte_in      = byte_ff;
                        bv_in        = bv_ff;
                        last_in      = last_ff;
                     end
                  end
                  REQ_RECEIVE: begin
                     if (id_ok && in_use_ff[idq] && req_max_len != '0 &&
                         count_ff[idq] != '0) begin
                        // Dequeue now; the bytes follow from the store.
                        rsp_valid_in  = pop ? 1'b0 : rsp_valid_ff;
                        status_in     = status_ff;
                        last_in       = last_ff;
                        sl_re         = 1'b1;
                        rq_in         = idq;
                        rs_in         = rslot_ff[idq];
                        mlen_in       = (int'(req_max_len) > RECV_CAP) ?
                                        LEN_W'(RECV_CAP) : req_max_len;
                        rslot_in[idq] = (rslot_ff[idq] == SW'(DEPTH - 1)) ?
                                        '0 : rslot_ff[idq] + SW'(1);
                        count_in[idq] = count_ff[idq] - CW'(1);
                        state_in      = ST_LEN;
                     end
                  end
                  REQ_DESTROY: begin
                     if (id_ok) begin
                        in_use_in[idq] = 1'b0;
                        if (prog_ff != '0 && sq_ff == req_queue_id) begin
                           ovf_in = 1'b1;
                        end
                        status_in = STATUS_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LEN: begin
            // Delivered length is the stored length cut to the buffer size.
            if (CMPW'(mlen_ff) < len_c) begin
               len_c = CMPW'(mlen_ff);
            end
            len_in   = LW'(len_c);
            issue_in = '0;
            sent_in  = '0;
            dv_in    = 1'b0;
            state_in = ST_STREAM;
         end
         ST_STREAM: begin
            if (len_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_OK;
                  value_in     = '0;
                  byte_in      = '0;
                  bv_in        = 1'b0;
                  last_in      = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               // The RAM read register holds one byte ahead of the response word.
               move  = dv_ff && out_free;
               issue = (issue_ff < len_ff) && (!dv_ff || move);
               if (issue) begin
                  msg_re   = 1'b1;
                  issue_in = issue_ff + LW'(1);
               end
               dv_in = issue ? 1'b1 : (move ? 1'b0 : dv_ff);
               if (move) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_OK;
                  value_in     = LEN_W'(len_ff);
                  byte_in      = msg_rdata;
                  bv_in        = 1'b1;
                  last_in      = (sent_ff + LW'(1) == len_ff);
                  sent_in      = sent_ff + LW'(1);
                  if (sent_ff + LW'(1) == len_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prog_ff      <= '0;
         ovf_ff       <= 1'b0;
         sq_ff        <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < QUEUES; q++) begin
            in_use_ff[q] <= 1'b0;
            wslot_ff[q]  <= '0;
            rslot_ff[q]  <= '0;
            count_ff[q]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prog_ff      <= prog_in;
         ovf_ff       <= ovf_in;
         sq_ff        <= sq_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         in_use_ff    <= in_use_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         count_ff     <= count_in;
      end
      rq_ff     <= rq_in;
      rs_ff     <= rs_in;
      mlen_ff   <= mlen_in;
      len_ff    <= len_in;
      issue_ff  <= issue_in;
      sent_ff   <= sent_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      byte_ff   <= byte_in;
      bv_ff     <= bv_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_value      = value_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_last       = last_ff;

   // A receive in progress holds off new requests.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request accepted during a receive");

   // A message byte always comes with success status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid) |-> (rsp_status == STATUS_OK))
      else $error("message byte with error status");

   // An error word is a single closing word with no value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ERROR) |->
      (rsp_last && rsp_value == '0 && !rsp_byte_valid))
      else $error("malformed error word");

   // The byte read ahead never exceeds the delivered length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> (issue_ff <= len_ff && sent_ff <= issue_ff))
      else $error("receive byte counters out of order");

endmodule
